FILE: rtl/core/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

	// Header bytes and the check seed they leave behind (first xor second)
	localparam logic [7:0] HDR_FIRST  = 8'hA0;
	localparam logic [7:0] HDR_SECOND = 8'hA1;
	localparam logic [7:0] HDR_SEED   = HDR_FIRST ^ HDR_SECOND;

	// Result transaction layout on the master-side tdata
	localparam int IDX_W      = 4;
	localparam int WORD_W     = 64;
	localparam int CHK_W      = 8;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_PAD_W  = OUT_DATA_W - IDX_W - WORD_W - 1 - CHK_W;

	// Controller states
	typedef enum logic [2:0] {
		ST_HUNT,   // looking for the first header byte
		ST_SYNC,   // expecting the second header byte
		ST_PAY,    // collecting payload bytes
		ST_CHK,    // check byte
		ST_TRL,    // trailing byte, closes the frame
		ST_RD,     // frame store read of one word
		ST_OUT,    // word presented on the output
		ST_FAIL    // check failure status presented
	} sfd_state_t;

	// Controller to datapath
	typedef struct packed {
		logic start;     // clear position, word counter, seed the check
		logic wr;        // store accepted byte and advance position
		logic pay;       // fold accepted byte into the running check
		logic chk;       // capture accepted byte as check byte
		logic rd;        // read frame store row at word counter
		logic word_inc;  // advance word counter
		logic fail_sel;  // output carries the failure status
	} sfd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_hdr1;   // input byte is the first header byte
		logic is_hdr2;   // input byte is the second header byte
		logic last_pay;  // position is at the last payload byte
		logic match;     // running check equals captured check byte
		logic last_word; // word counter is at the final word
	} sfd_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_dpath
	import sfd_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 72
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [7:0]            rx_byte,
	input  wire sfd_cmd_t              cmd,
	output sfd_sts_t                   sts,
	output logic [OUT_DATA_W-1:0]      out_data
);

	localparam int FRAME_BYTES = PAYLOAD_BYTES + 2;
	localparam int FRAME_WORDS = (FRAME_BYTES + 7) / 8;
	localparam int ROW_W       = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
	localparam int TAIL        = FRAME_BYTES % 8;

	localparam logic [ROW_W-1:0] LP_ROW    = ROW_W'((PAYLOAD_BYTES - 1) / 8);
	localparam logic [2:0]       LP_LANE   = 3'((PAYLOAD_BYTES - 1) % 8);
	localparam logic [ROW_W-1:0] LAST_WORD = ROW_W'(FRAME_WORDS - 1);
	localparam logic [WORD_W-1:0] LAST_MASK =
		(TAIL == 0) ? {WORD_W{1'b1}} : ((64'd1 << (8 * TAIL)) - 64'd1);

	logic [WORD_W-1:0] mem_q [FRAME_WORDS];
	logic [WORD_W-1:0] rd_data_q;
	logic [ROW_W-1:0]  row_q;
	logic [2:0]        lane_q;
	logic [ROW_W-1:0]  word_q;
	logic [CHK_W-1:0]  run_chk_q;
	logic [CHK_W-1:0]  chk_byte_q;
	logic [WORD_W-1:0] word_masked;

	// Write position: row of the frame store and byte lane within it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			lane_q <= '0;
		end else if (cmd.start) begin
			row_q  <= '0;
			lane_q <= '0;
		end else if (cmd.wr) begin
			lane_q <= lane_q + 3'd1;
			if (lane_q == 3'd7) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// Output word counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (cmd.start) begin
			word_q <= '0;
		end else if (cmd.word_inc) begin
			word_q <= word_q + 1'b1;
		end
	end

	// Running xor over header and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_chk_q <= '0;
		end else if (cmd.start) begin
			run_chk_q <= HDR_SEED;
		end else if (cmd.pay) begin
			run_chk_q <= run_chk_q ^ rx_byte;
		end
	end

	// Check byte capture
	always_ff @(posedge clk) begin
		if (cmd.chk) begin
			chk_byte_q <= rx_byte;
		end
	end

	// Frame store: byte-lane write, registered word read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[row_q][8*lane_q +: 8] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem_q[word_q];
		end
	end

	// Status
	assign sts.is_hdr1   = (rx_byte == HDR_FIRST);
	assign sts.is_hdr2   = (rx_byte == HDR_SECOND);
	assign sts.last_pay  = (row_q == LP_ROW) && (lane_q == LP_LANE);
	assign sts.match     = (run_chk_q == chk_byte_q);
	assign sts.last_word = (word_q == LAST_WORD);

	// Bytes past the frame end read as zero
	assign word_masked = (word_q == LAST_WORD) ? (rd_data_q & LAST_MASK) : rd_data_q;

	// Result packing: index, word, ok, check, zero pad
	always_comb begin
		if (cmd.fail_sel) begin
			out_data = {{OUT_PAD_W{1'b0}}, run_chk_q, 1'b0, {WORD_W{1'b0}}, {IDX_W{1'b0}}};
		end else begin
			out_data = {{OUT_PAD_W{1'b0}}, run_chk_q, 1'b1, word_masked, IDX_W'(word_q)};
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sfd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_ctrl
	import sfd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	output logic          out_last,
	input  wire logic     out_ready,
	input  wire sfd_sts_t sts,
	output sfd_cmd_t      cmd
);

	sfd_state_t state_q;
	sfd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands; ready/valid depend on state only, so an
	// accepted transaction is in_valid (or out_ready) in a state that opens that side
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_last  = 1'b0;
		unique case (state_q)
			ST_HUNT: begin
				in_ready = 1'b1;
				if (in_valid && sts.is_hdr1) begin
					state_d = ST_SYNC;
				end
			end
			ST_SYNC: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.is_hdr2) begin
						cmd.start = 1'b1;
						state_d   = ST_PAY;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_PAY: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.wr  = 1'b1;
					cmd.pay = 1'b1;
					if (sts.last_pay) begin
						state_d = ST_CHK;
					end
				end
			end
			ST_CHK: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.wr  = 1'b1;
					cmd.chk = 1'b1;
					state_d = ST_TRL;
				end
			end
			ST_TRL: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.wr  = 1'b1;
					state_d = sts.match ? ST_RD : ST_FAIL;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				out_last  = sts.last_word;
				if (out_ready) begin
					if (sts.last_word) begin
						state_d = ST_HUNT;
					end else begin
						cmd.word_inc = 1'b1;
						state_d      = ST_RD;
					end
				end
			end
			ST_FAIL: begin
				out_valid    = 1'b1;
				out_last     = 1'b1;
				cmd.fail_sel = 1'b1;
				if (out_ready) begin
					state_d = ST_HUNT;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/sensor_frame_deframer_xor_check.sv
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  tdata[7:0] rx_byte
// m_*      out  m_tvalid/m_tready  tdata word_index, frame_word, check_ok,
//                                  computed_check; tlast last
//
// Each received byte is taken in one cycle while the deframer is collecting.
// A passing frame yields ceil((PAYLOAD_BYTES+2)/8) words, each first read from
// the frame store and then presented, and the next word is read once it is taken.
// A failing frame yields one status transaction. While results are pending
// s_tready is low; m_tready low holds the current transaction in place.
// Reset is asynchronous; the frame store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_deframer_xor_check
	import sfd_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 72
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,  // [7:0] rx_byte
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [3:0] word_index, [67:4] frame_word, [68] check_ok,
	// [76:69] computed_check, [79:77] zero
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast
);

	localparam int FRAME_WORDS = (PAYLOAD_BYTES + 2 + 7) / 8;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_WORDS - 1);

	sfd_cmd_t cmd;
	sfd_sts_t sts;

	sfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sfd_dpath #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (m_tdata)
	);

	// Input and output never open together
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while a result is pending");

	// A passing frame ends on its final word
	a_pass_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast && m_tdata[68]) |-> (m_tdata[3:0] == LAST_IDX))
		else $error("last word of passing frame has wrong index");

	// Failure status is a single zeroed, last-marked transaction
	a_fail_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[68]) |-> (m_tlast && m_tdata[67:0] == 68'd0))
		else $error("malformed failure status");

	// After the final transaction the deframer hunts again
	a_back_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("not back to hunting after frame end");

endmodule

`default_nettype wire
